// File: rtl/ulaq_pkg.sv
`default_nettype none

package ulaq_pkg;

    // Default geometry of the line queue.
    localparam int LINE_LEN_DEF   = 64;
    localparam int LINE_SLOTS_DEF = 5;

    // A line is committed when this byte is received.
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // Commands carried by the opcode field of an input word.
    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_READ = 1'b1
    } t_opcode;

    // Read sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CHECK,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

// File: rtl/uart_line_assembler_queue.sv
`default_nettype none

// Line queue for a byte stream. Each received byte (opcode 0) is written
// straight into the line slot being assembled, at a position that wraps after
// LINE_LEN bytes; a newline byte is stored too and commits the line, after
// which the write slot moves on round a ring of LINE_SLOTS slots, overwriting
// unread lines without warning. A read (opcode 1) returns the oldest line one
// word per byte, stopping at its length or at its first zero byte, with last
// set on the final word, and frees its slot as soon as the read is taken; an
// empty queue returns one word with queue_empty and last set, and an empty line
// one word of zero with last set. Every byte of a read makes a trip through
// the registered read port of the line memory before it is checked for zero;
// the input is stalled for the whole of a read.
module uart_line_assembler_queue #(
    parameter int LINE_LEN   = ulaq_pkg::LINE_LEN_DEF,
    parameter int LINE_SLOTS = ulaq_pkg::LINE_SLOTS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Input channel.
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_opcode,
    input  wire logic [7:0] i_data_byte,
    // Result channel.
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic      [7:0] o_line_byte,
    output logic            o_queue_empty,
    output logic            o_last
);

    localparam int POS_W  = $clog2(LINE_LEN);
    localparam int SLOT_W = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
    localparam int DEPTH  = LINE_LEN * LINE_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);

    ulaq_pkg::t_state r_state, n_state;

    logic [POS_W-1:0]  r_count;
    logic [SLOT_W-1:0] r_wslot;
    logic [SLOT_W-1:0] r_rslot;
    logic [POS_W-1:0]  r_length [LINE_SLOTS];

    logic [POS_W-1:0]  r_idx;
    logic [POS_W-1:0]  r_len;
    logic [ADDR_W-1:0] r_base;
    logic [7:0]        r_prev;
    logic              r_have_prev;
    logic              r_empty_rd;

    logic              r_out_valid;
    logic [7:0]        r_line_byte;
    logic              r_queue_empty;
    logic              r_last;

    logic              w_in_acc;
    logic              w_acc_byte;
    logic              w_acc_read;
    logic              w_queue_empty;
    logic [POS_W-1:0]  w_head_len;
    logic [POS_W-1:0]  w_pos_next;
    logic [SLOT_W-1:0] w_wslot_next;
    logic [SLOT_W-1:0] w_rslot_next;
    logic              w_is_newline;
    logic              w_out_free;
    logic [7:0]        w_rdata;
    logic              w_rd_zero;
    logic              w_at_end;
    logic              w_rd_en;
    logic              w_emit;
    logic [7:0]        w_emit_byte;
    logic              w_emit_last;
    logic              w_advance;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;

    // Handshake and command decode.
    assign o_in_stall = (r_state != ulaq_pkg::ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_acc_byte = w_in_acc && (i_opcode == ulaq_pkg::OP_BYTE);
    assign w_acc_read = w_in_acc && (i_opcode == ulaq_pkg::OP_READ);
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Assembly position and slot arithmetic, all wrapping.
    assign w_pos_next   = (r_count == POS_W'(LINE_LEN - 1)) ? '0 : r_count + 1'b1;
    assign w_wslot_next = (r_wslot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : r_wslot + 1'b1;
    assign w_rslot_next = (r_rslot == SLOT_W'(LINE_SLOTS - 1)) ? '0 : r_rslot + 1'b1;
    assign w_is_newline = (i_data_byte == ulaq_pkg::NEWLINE_BYTE);
    assign w_queue_empty = (r_rslot == r_wslot);
    assign w_head_len   = r_length[r_rslot];

    // Line memory addresses: slot base plus position in the line.
    assign w_waddr = ADDR_W'(r_wslot) * ADDR_W'(LINE_LEN) + ADDR_W'(r_count);
    assign w_raddr = r_base + ADDR_W'(r_idx);

    ulaq_line_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_acc_byte),
        .i_waddr (w_waddr),
        .i_wdata (i_data_byte),
        .i_re    (w_rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_zero = (w_rdata == 8'h00);
    assign w_at_end  = ((r_idx + 1'b1) == r_len);

    // Next state of the read sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ulaq_pkg::ST_IDLE: begin
                if (w_acc_read) begin
                    if (w_queue_empty || (w_head_len == '0)) begin
                        n_state = ulaq_pkg::ST_FLUSH;
                    end else begin
                        n_state = ulaq_pkg::ST_FETCH;
                    end
                end
            end
            ulaq_pkg::ST_FETCH: begin
                n_state = ulaq_pkg::ST_CHECK;
            end
            ulaq_pkg::ST_CHECK: begin
                if (w_rd_zero) begin
                    n_state = ulaq_pkg::ST_FLUSH;
                end else if (!r_have_prev || w_out_free) begin
                    n_state = w_at_end ? ulaq_pkg::ST_FLUSH : ulaq_pkg::ST_FETCH;
                end
            end
            ulaq_pkg::ST_FLUSH: begin
                if (w_out_free) begin
                    n_state = ulaq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ulaq_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: memory reads and words handed to the output register.
    // A byte is only sent once the following byte is known, so that the last
    // flag can be set on it.
    always_comb begin
        w_rd_en     = 1'b0;
        w_emit      = 1'b0;
        w_emit_byte = r_prev;
        w_emit_last = 1'b0;
        w_advance   = 1'b0;
        case (r_state)
            ulaq_pkg::ST_IDLE: begin
            end
            ulaq_pkg::ST_FETCH: begin
                w_rd_en = 1'b1;
            end
            ulaq_pkg::ST_CHECK: begin
                if (!w_rd_zero && (!r_have_prev || w_out_free)) begin
                    w_emit    = r_have_prev;
                    w_advance = 1'b1;
                end
            end
            ulaq_pkg::ST_FLUSH: begin
                w_emit      = w_out_free;
                w_emit_byte = r_have_prev ? r_prev : 8'h00;
                w_emit_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control state: sequencer, assembly position, slots and line lengths.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ulaq_pkg::ST_IDLE;
            r_count <= '0;
            r_wslot <= '0;
            r_rslot <= '0;
            for (int s = 0; s < LINE_SLOTS; s++) begin
                r_length[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_acc_byte) begin
                if (w_is_newline) begin
                    r_length[r_wslot] <= w_pos_next;
                    r_count           <= '0;
                    r_wslot           <= w_wslot_next;
                end else begin
                    r_count <= w_pos_next;
                end
            end
            // No write can come in while a read runs, so the slot is freed
            // as soon as the read is taken.
            if (w_acc_read && !w_queue_empty) begin
                r_length[r_rslot] <= '0;
                r_rslot           <= w_rslot_next;
            end
        end
    end

    // Read working registers.
    always_ff @(posedge i_clk) begin
        if (w_acc_read) begin
            r_idx       <= '0;
            r_len       <= w_head_len;
            r_base      <= ADDR_W'(r_rslot) * ADDR_W'(LINE_LEN);
            r_have_prev <= 1'b0;
            r_empty_rd  <= w_queue_empty;
        end else if (w_advance) begin
            r_idx       <= r_idx + 1'b1;
            r_prev      <= w_rdata;
            r_have_prev <= 1'b1;
        end
    end

    // Output register: loads a word whenever it is empty or being taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_line_byte   <= w_emit_byte;
            r_queue_empty <= (r_state == ulaq_pkg::ST_FLUSH) && r_empty_rd;
            r_last        <= w_emit_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_line_byte   = r_line_byte;
    assign o_queue_empty = r_queue_empty;
    assign o_last        = r_last;

endmodule

`default_nettype wire

// File: rtl/ulaq_line_ram.sv
`default_nettype none

module ulaq_line_ram #(
    parameter int DEPTH  = ulaq_pkg::LINE_LEN_DEF * ulaq_pkg::LINE_SLOTS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [7:0]        i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [7:0]        o_rdata
);

    // One byte per entry, one line slot after another.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: tb/uart_line_assembler_queue_tb.sv
module uart_line_assembler_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN   = ulaq_pkg::LINE_LEN_DEF;
    localparam int SLOTS = ulaq_pkg::LINE_SLOTS_DEF;

    // One word of the result channel.
    typedef struct packed {
        logic [7:0] ch;
        logic       empty;
        logic       last;
    } t_line_word;

    // Tracks the assembly buffer and the ring of line slots, and holds the
    // words that each read is due to return.
    class line_ring_checker;
        bit [7:0]    asm_buf [LEN];
        int unsigned asm_pos;
        bit [7:0]    slot_text [SLOTS][LEN];
        int unsigned slot_len [SLOTS];
        int unsigned wr_slot;
        int unsigned rd_slot;
        t_line_word  awaited [$];
        int          errors;
        int          reads;
        int          empty_reads;
        int          lines_committed;
        int          blank_commits;
        int          wraps;
        int          words_checked;

        // Updates the line queue for an accepted input word.
        function void take_word(ulaq_pkg::t_opcode op, logic [7:0] b);
            int unsigned n;
            if (op == ulaq_pkg::OP_BYTE) begin
                asm_buf[asm_pos] = b;
                asm_pos = (asm_pos + 1) % LEN;
                if (asm_pos == 0) wraps++;
                // A newline closes the line, itself included.
                if (b == ulaq_pkg::NEWLINE_BYTE) begin
                    for (int unsigned i = 0; i < asm_pos; i++)
                        slot_text[wr_slot][i] = asm_buf[i];
                    slot_len[wr_slot] = asm_pos;
                    if (asm_pos == 0) blank_commits++;
                    asm_pos = 0;
                    wr_slot = (wr_slot + 1) % SLOTS;
                    lines_committed++;
                end
            end else begin
                reads++;
                if (rd_slot == wr_slot) begin
                    awaited.push_back('{ch: 8'h00, empty: 1'b1, last: 1'b1});
                    empty_reads++;
                end else begin
                    // The line ends at its length or at its first zero byte.
                    n = 0;
                    while (n < slot_len[rd_slot] && slot_text[rd_slot][n] != 8'h00) n++;
                    if (n == 0) begin
                        awaited.push_back('{ch: 8'h00, empty: 1'b0, last: 1'b1});
                    end else begin
                        for (int unsigned i = 0; i < n; i++)
                            awaited.push_back('{ch: slot_text[rd_slot][i], empty: 1'b0,
                                                last: (i + 1 == n)});
                    end
                    slot_len[rd_slot] = 0;
                    rd_slot = (rd_slot + 1) % SLOTS;
                end
            end
        endfunction

        // Compares a result word with the oldest one still awaited.
        function void check_word(logic [7:0] ch, logic empty, logic last);
            t_line_word want;
            if (awaited.size() == 0) begin
                $error("Unexpected result word: line_byte %02h queue_empty %0b last %0b",
                       ch, empty, last);
                errors++;
                return;
            end
            want = awaited.pop_front();
            words_checked++;
            if (ch !== want.ch) begin
                $error("line_byte: expected %02h, got %02h", want.ch, ch);
                errors++;
            end
            if (empty !== want.empty) begin
                $error("queue_empty: expected %0b, got %0b", want.empty, empty);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_stall;
    logic       i_opcode    = ulaq_pkg::OP_BYTE;
    logic [7:0] i_data_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_line_byte;
    logic       o_queue_empty;
    logic       o_last;

    line_ring_checker chk;
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int words_sent = 0;

    uart_line_assembler_queue u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_line_byte  (o_line_byte),
        .o_queue_empty(o_queue_empty),
        .o_last       (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Offers one word, with an optional gap first, and waits until it is taken.
    task automatic send_word(input ulaq_pkg::t_opcode op, input logic [7:0] b);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        chk.take_word(op, b);
        words_sent++;
    endtask

    // Sends a line body of the given length followed by a newline. The body
    // holds no newline but now and then a zero byte.
    task automatic send_line(input int unsigned body_len);
        logic [7:0] b;
        repeat (body_len) begin
            if ($urandom_range(99) < 8) begin
                b = 8'h00;
            end else begin
                do b = 8'($urandom_range(255)); while (b == ulaq_pkg::NEWLINE_BYTE);
            end
            send_word(ulaq_pkg::OP_BYTE, b);
        end
        send_word(ulaq_pkg::OP_BYTE, ulaq_pkg::NEWLINE_BYTE);
    endtask

    // Mostly well-formed lines and reads, some stray bytes, and bursts of
    // lines without reads that can lap the read slot.
    task automatic send_random_burst();
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 55) begin
            send_line($urandom_range(12, 0));
            if ($urandom_range(99) < 60)
                send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
        end else if (kind < 75) begin
            send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
        end else if (kind < 85) begin
            send_word(ulaq_pkg::OP_BYTE, 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(6, 2)) send_line($urandom_range(4, 0));
            repeat ($urandom_range(3, 1))
                send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
        end
    endtask

    // Result side: checks every accepted word and drives the stall, including
    // one long hold-off while the sender keeps offering words.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            chk.check_word(o_line_byte, o_queue_empty, o_last);
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    initial begin
        chk = new;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Read of an empty queue, with a non-zero byte in the ignored field.
        send_word(ulaq_pkg::OP_READ, 8'hFF);
        // A line whose first byte is zero reads back as an empty line.
        send_word(ulaq_pkg::OP_BYTE, 8'h00);
        send_word(ulaq_pkg::OP_BYTE, ulaq_pkg::NEWLINE_BYTE);
        send_word(ulaq_pkg::OP_READ, 8'h00);
        // A zero byte in the middle cuts the line short.
        send_word(ulaq_pkg::OP_BYTE, 8'hFF);
        send_word(ulaq_pkg::OP_BYTE, 8'h41);
        send_word(ulaq_pkg::OP_BYTE, 8'h00);
        send_word(ulaq_pkg::OP_BYTE, 8'h42);
        send_word(ulaq_pkg::OP_BYTE, ulaq_pkg::NEWLINE_BYTE);
        send_word(ulaq_pkg::OP_READ, 8'h55);
        // Top bit set, and the newline returned as part of the line.
        send_word(ulaq_pkg::OP_BYTE, 8'h80);
        send_word(ulaq_pkg::OP_BYTE, ulaq_pkg::NEWLINE_BYTE);
        send_word(ulaq_pkg::OP_READ, 8'hAA);
        send_word(ulaq_pkg::OP_READ, 8'h00);
        // Five commits in a row bring the write slot round to the read slot,
        // so the waiting lines are lost and the queue looks empty.
        repeat (SLOTS) send_word(ulaq_pkg::OP_BYTE, ulaq_pkg::NEWLINE_BYTE);
        send_word(ulaq_pkg::OP_READ, 8'h0F);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            if (ph == 0) begin
                // Hold the result side off so that a read backs up into the input.
                hold_left = 240;
                repeat (3) begin
                    send_line($urandom_range(10, 4));
                    send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
                end
            end else if (ph == 1) begin
                // From position zero, the newline lands on the last position and commits an empty line.
                send_line(LEN - 1);
                send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
            end else if (ph == 3) begin
                // The assembly position wraps before the newline arrives.
                send_line(LEN + $urandom_range(6, 1));
                send_word(ulaq_pkg::OP_READ, 8'($urandom_range(255)));
            end
            // Each phase tops the running total up to its share of the run.
            while (words_sent < 45 * (ph + 1)) send_random_burst();
        end
        i_in_valid <= 1'b0;

        // Drain, then give a possible stray word time to show up.
        while (chk.awaited.size() != 0) @(posedge i_clk);
        repeat (2 * LEN + 8) @(posedge i_clk);

        $display("Run covered %0d input words, %0d reads (%0d on an empty queue), %0d lines.",
                 words_sent, chk.reads, chk.empty_reads, chk.lines_committed);
        $display("Checked %0d result words; %0d assembly wraps, %0d zero-length lines.",
                 chk.words_checked, chk.wraps, chk.blank_commits);
        if (chk.errors == 0 && chk.awaited.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
